>>> sv/sodlp_pkg.sv
// Package with shared types, constants and a helper function of the dither line packer.
package sodlp_pkg;

  // Default side length of the square threshold matrix.
  localparam int unsigned MatrixSideDefault = 16;

  // Field widths of the input, result and configuration transactions.
  localparam int unsigned CmdW       = 2;
  localparam int unsigned TblIdxW    = 8;
  localparam int unsigned TblValW    = 8;
  localparam int unsigned LineNumW   = 13;
  localparam int unsigned GrayW      = 8;
  localparam int unsigned AdvanceW   = 15;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned ByteIdxW   = 10;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 14;
  localparam int unsigned WidthW     = 14;
  localparam int unsigned OriginW    = 13;
  localparam int unsigned StepWholeW = 14;
  localparam int unsigned StepRemW   = 13;
  localparam int unsigned MatrixPosW = 4;

  // Fixed-point shift of the reciprocal used for the small modulo.
  localparam int unsigned RecipShift = 16;
  localparam int unsigned RecipW     = 17;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_START  = 2'd1,
    CMD_SAMPLE = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SCALED_WIDTH   = 2'd0,
    REG_X_ORIGIN       = 2'd1,
    REG_STEP_WHOLE     = 2'd2,
    REG_STEP_REMAINDER = 2'd3
  } reg_idx_e;

  // Remainder of a 13-bit value by a small constant side, using a multiply by
  // the precomputed reciprocal and a single correction step.
  function automatic logic [MatrixPosW-1:0] mod_side(
    input logic [LineNumW-1:0] v,
    input logic [4:0]          side,
    input logic [RecipW-1:0]   recip
  );
    logic [29:0] prod;
    logic [13:0] quo;
    logic [18:0] prod_back;
    logic [18:0] v_ext;
    logic [18:0] rem;
    prod      = 30'(v) * 30'(recip);
    quo       = prod[29:RecipShift];
    prod_back = 19'(quo) * 19'(side);
    v_ext     = 19'(v);
    if (prod_back > v_ext) begin
      rem = v_ext + 19'(side) - prod_back;
    end else begin
      rem = v_ext - prod_back;
    end
    return rem[MatrixPosW-1:0];
  endfunction

endpackage

>>> sv/sodlp_if.sv
// Channel interfaces of the dither line packer: input items, results and configuration writes.
interface sodlp_in_if;
  import sodlp_pkg::*;
  logic                valid;
  logic                ready;
  logic [CmdW-1:0]     cmd;
  logic [TblIdxW-1:0]  table_index;
  logic [TblValW-1:0]  table_value;
  logic [LineNumW-1:0] line_number;
  logic [GrayW-1:0]    gray_sample;

  modport source (output valid, cmd, table_index, table_value, line_number, gray_sample,
                  input ready);
  modport sink   (input valid, cmd, table_index, table_value, line_number, gray_sample,
                  output ready);
endinterface

interface sodlp_out_if;
  import sodlp_pkg::*;
  logic                valid;
  logic                ready;
  logic [AdvanceW-1:0] source_advance;
  logic                byte_valid;
  logic [ByteW-1:0]    byte_value;
  logic [ByteIdxW-1:0] byte_index;
  logic                line_done;

  modport source (output valid, source_advance, byte_valid, byte_value, byte_index, line_done,
                  input ready);
  modport sink   (input valid, source_advance, byte_valid, byte_value, byte_index, line_done,
                  output ready);
endinterface

interface sodlp_cfg_if;
  import sodlp_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_index;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

>>> sv/scaled_ordered_dither_line_packer_top.sv
// Top level of the scaled ordered-dither line packer.
//
// The block turns a row of 8-bit gray samples into packed 1-bit printer dots.
// Load transactions fill a MATRIX_SIDE x MATRIX_SIDE threshold matrix, a
// start-line transaction selects the matrix row from the line number and
// takes the packing origin from x_origin, and each gray sample then yields
// exactly one result: the dot is printed when the sample is less than or
// equal to the threshold at its column. A result carries a packed byte when
// the byte fills up or the row ends, and always carries the source advance
// (whole step plus a Bresenham carry). Loads, start-line transactions,
// samples outside an active row and unknown commands produce no result.
// The block accepts one transaction per clock cycle unless a stalled output
// holds intake. At acceptance of a sample the position state is updated and
// the threshold memory is read (registered read) into the pipeline stage,
// which compares and packs into the output register. A stalled output only
// blocks intake once both the pipeline stage and the output register are
// full. Configuration writes are accepted in every cycle and must only be
// issued while no transaction is in flight. The threshold memory has no
// reset; entries must be loaded before they are used.
module scaled_ordered_dither_line_packer_top
  import sodlp_pkg::*;
#(
  parameter int unsigned MATRIX_SIDE = MatrixSideDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sodlp_cfg_if.sink   cfg_i,
  sodlp_in_if.sink    in_i,
  sodlp_out_if.source out_o
);

  localparam logic [4:0]        SideW   = 5'(MATRIX_SIDE);
  localparam logic [RecipW-1:0] SideRcp = RecipW'((2 ** RecipShift + MATRIX_SIDE - 1) /
                                                  MATRIX_SIDE);
  localparam logic [TblIdxW-1:0] SideT  = TblIdxW'(MATRIX_SIDE);

  // Everything the compare-and-pack stage needs to know about one transaction.
  typedef struct packed {
    logic                start;
    logic [GrayW-1:0]    gray;
    logic [ByteW-1:0]    mask;
    logic                last;
    logic                emit;
    logic [ByteIdxW-1:0] ptr;
    logic [AdvanceW-1:0] advance;
  } stage_t;

  // Configuration registers.
  logic [WidthW-1:0]     scaled_width_q;
  logic [OriginW-1:0]    x_origin_q;
  logic [StepWholeW-1:0] step_whole_q;
  logic [StepRemW-1:0]   step_rem_q;
  // x_origin modulo the matrix side, refreshed whenever x_origin is written.
  logic [MatrixPosW-1:0] xo_mod_q;

  // Row position state, advanced at acceptance.
  logic [WidthW-1:0]     dot_pos_q, dot_pos_d;
  logic [MatrixPosW-1:0] dot_mod_q, dot_mod_d;
  logic [ByteW-1:0]      bit_mask_q, bit_mask_d;
  logic [WidthW-1:0]     step_err_q, step_err_d;
  logic [MatrixPosW-1:0] mat_row_q, mat_row_d;
  logic [ByteIdxW-1:0]   byte_ptr_q, byte_ptr_d;
  logic                  active_q, active_d;

  // Threshold memory with registered read.
  logic [TblValW-1:0] matrix_mem [2**TblIdxW];
  logic [TblValW-1:0] thr_q;
  logic [TblIdxW-1:0] rd_addr;

  // Pipeline stage and output register.
  logic               s1_valid_q, s1_valid_d;
  stage_t             s1_q, s1_d;
  logic [ByteW-1:0]   acc_q, acc_d;
  logic               out_valid_q, out_valid_d;
  logic [AdvanceW-1:0] out_adv_q;
  logic               out_bv_q;
  logic [ByteW-1:0]   out_byte_q;
  logic [ByteIdxW-1:0] out_idx_q;
  logic               out_done_q;

  logic               in_acc;
  logic               s1_adv;
  logic               s1_is_sample;
  logic               take_sample;
  logic               take_start;
  logic [4:0]         col_sum;
  logic [MatrixPosW-1:0] col;
  logic [WidthW:0]    err_sum;
  logic               carry;
  logic [WidthW-1:0]  dot_next;
  logic               last;
  logic [ByteW-1:0]   acc_new;

  // Configuration port: always ready, registers take effect at once.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scaled_width_q <= WidthW'(1);
      x_origin_q     <= '0;
      step_whole_q   <= StepWholeW'(1);
      step_rem_q     <= '0;
      xo_mod_q       <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        REG_SCALED_WIDTH:   scaled_width_q <= cfg_i.wdata[WidthW-1:0];
        REG_X_ORIGIN: begin
          x_origin_q <= cfg_i.wdata[OriginW-1:0];
          xo_mod_q   <= mod_side(cfg_i.wdata[OriginW-1:0], SideW, SideRcp);
        end
        REG_STEP_WHOLE:     step_whole_q <= cfg_i.wdata[StepWholeW-1:0];
        REG_STEP_REMAINDER: step_rem_q   <= cfg_i.wdata[StepRemW-1:0];
        default: ;
      endcase
    end
  end

  // Intake handshake. The stage moves on when it holds no sample or the output
  // register is free or being emptied in this cycle.
  assign s1_is_sample = s1_valid_q && !s1_q.start;
  assign s1_adv       = s1_valid_q && (!s1_is_sample || !out_valid_q || out_o.ready);
  assign in_i.ready   = !s1_valid_q || s1_adv;
  assign in_acc       = in_i.valid && in_i.ready;

  assign take_start  = in_acc && (in_i.cmd == CMD_START);
  assign take_sample = in_acc && (in_i.cmd == CMD_SAMPLE) && active_q &&
                       (dot_pos_q < scaled_width_q);

  // Matrix column of the current dot, kept modulo the side without a divider.
  assign col_sum = 5'(xo_mod_q) + 5'(dot_mod_q);
  assign col     = (col_sum >= SideW) ? MatrixPosW'(col_sum - SideW) : col_sum[MatrixPosW-1:0];
  assign rd_addr = TblIdxW'(TblIdxW'(mat_row_q) * SideT) + TblIdxW'(col);

  // Bresenham step: at most one subtraction of the width per dot.
  assign err_sum  = (WidthW+1)'(step_err_q) + (WidthW+1)'(step_rem_q);
  assign carry    = err_sum >= (WidthW+1)'(scaled_width_q);
  assign dot_next = dot_pos_q + WidthW'(1);
  assign last     = dot_next >= scaled_width_q;

  always_comb begin
    dot_pos_d  = dot_pos_q;
    dot_mod_d  = dot_mod_q;
    bit_mask_d = bit_mask_q;
    step_err_d = step_err_q;
    mat_row_d  = mat_row_q;
    byte_ptr_d = byte_ptr_q;
    active_d   = active_q;
    if (take_start) begin
      mat_row_d  = mod_side(in_i.line_number, SideW, SideRcp);
      dot_pos_d  = '0;
      dot_mod_d  = '0;
      step_err_d = '0;
      bit_mask_d = ByteW'(8'd128 >> x_origin_q[2:0]);
      byte_ptr_d = x_origin_q[OriginW-1:3];
      active_d   = 1'b1;
    end else if (take_sample) begin
      step_err_d = carry ? WidthW'(err_sum - (WidthW+1)'(scaled_width_q))
                         : err_sum[WidthW-1:0];
      dot_pos_d  = dot_next;
      dot_mod_d  = (5'(dot_mod_q) + 5'd1 == SideW) ? '0 : dot_mod_q + MatrixPosW'(1);
      if (bit_mask_q == ByteW'(1)) begin
        bit_mask_d = ByteW'(8'd128);
        byte_ptr_d = byte_ptr_q + ByteIdxW'(1);
      end else begin
        bit_mask_d = bit_mask_q >> 1;
      end
      if (last) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_pos_q  <= '0;
      dot_mod_q  <= '0;
      bit_mask_q <= ByteW'(8'd128);
      step_err_q <= '0;
      mat_row_q  <= '0;
      byte_ptr_q <= '0;
      active_q   <= 1'b0;
    end else begin
      dot_pos_q  <= dot_pos_d;
      dot_mod_q  <= dot_mod_d;
      bit_mask_q <= bit_mask_d;
      step_err_q <= step_err_d;
      mat_row_q  <= mat_row_d;
      byte_ptr_q <= byte_ptr_d;
      active_q   <= active_d;
    end
  end

  // Threshold memory. The read is issued with the sample at acceptance and
  // holds while the stage waits, since nothing new is accepted meanwhile.
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_i.cmd == CMD_LOAD)) begin
      matrix_mem[in_i.table_index] <= in_i.table_value;
    end
    if (take_sample) begin
      thr_q <= matrix_mem[rd_addr];
    end
  end

  // First stage register.
  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_d       = s1_q;
    if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (take_start || take_sample) begin
      s1_valid_d   = 1'b1;
      s1_d.start   = take_start;
      s1_d.gray    = in_i.gray_sample;
      s1_d.mask    = bit_mask_q;
      s1_d.last    = last;
      s1_d.emit    = (bit_mask_q == ByteW'(1)) || last;
      s1_d.ptr     = byte_ptr_q;
      s1_d.advance = AdvanceW'(step_whole_q) + AdvanceW'(carry);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // Compare and pack. A start-line transaction clears the accumulator; a
  // completed byte restarts it empty.
  assign acc_new = acc_q | ((s1_q.gray <= thr_q) ? s1_q.mask : '0);

  always_comb begin
    acc_d = acc_q;
    if (s1_adv) begin
      if (s1_q.start || (s1_q.mask == ByteW'(1))) begin
        acc_d = '0;
      end else begin
        acc_d = acc_new;
      end
    end
  end

  assign out_valid_d = (s1_adv && s1_is_sample) ||
                       (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_is_sample) begin
      out_adv_q  <= s1_q.advance;
      out_bv_q   <= s1_q.emit;
      out_byte_q <= s1_q.emit ? acc_new : '0;
      out_idx_q  <= s1_q.emit ? s1_q.ptr : '0;
      out_done_q <= s1_q.last;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.source_advance = out_adv_q;
  assign out_o.byte_valid     = out_bv_q;
  assign out_o.byte_value     = out_byte_q;
  assign out_o.byte_index     = out_idx_q;
  assign out_o.line_done      = out_done_q;

endmodule
